// File: rtl/dspmb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dspmb_pkg;

  // Stream widths: input tuser carries the access kind, output tuser the event.
  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned IN_USER_W  = 3;
  localparam int unsigned OUT_DATA_W = 216;
  localparam int unsigned OUT_USER_W = 3;

  // Bus access kinds.
  localparam logic [2:0] CMD_WRITE = 3'd0;
  localparam logic [2:0] CMD_IRQ   = 3'd1;
  localparam logic [2:0] CMD_CHECK = 3'd2;
  localparam logic [2:0] CMD_READ  = 3'd3;
  localparam logic [2:0] CMD_BOOT  = 3'd4;

  // Event codes reported with each result.
  localparam logic [2:0] EV_NONE    = 3'd0;
  localparam logic [2:0] EV_SETUP   = 3'd1;
  localparam logic [2:0] EV_FRAME   = 3'd2;
  localparam logic [2:0] EV_RENDER  = 3'd3;
  localparam logic [2:0] EV_UNKNOWN = 3'd4;

  // Command opcodes in the top byte of the first command word.
  localparam logic [7:0] OP_SETUP = 8'h81;
  localparam logic [7:0] OP_FRAME = 8'h82;

  // Mail words posted to the host.
  localparam logic [31:0] MAIL_REPLY_HDR = 32'hDCD1_0004;
  localparam logic [31:0] MAIL_BOOT_HDR  = 32'hDCD1_0000;
  localparam logic [31:0] MAIL_TAG       = 32'hF355_0000;
  localparam logic [31:0] MAIL_RENDERED  = 32'hF355_FF00;
  localparam logic [31:0] MAIL_PRESENT   = 32'h8000_0000;

endpackage

`default_nettype wire

// File: rtl/dspmb_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module dspmb_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// File: rtl/dsp_mailbox_command_engine.sv
// Audio-processor side of a host/DSP mailbox.
// Slave stream: one bus access per transfer; tuser holds the access kind
// (write mail, assert interrupt, check mail, read mail, boot) and tdata the
// mail word. Master stream: exactly one result transfer per access, with the
// read data, interrupt and overflow flags, render addresses, latched frame
// settings and the render counter in tdata and the event code in tuser.
// One access is worked at a time; s_axis_tready is high only while idle.
// Path from accept to the result register: plain accesses go through the
// execute step only; check/read add a registered queue read, boot pushes two
// mail words, a command reply pushes two after the command runs, a subframe
// render adds an 8-step shift-add for the address offset and two address
// adds, and a frame command adds a subtraction and the 32-step restoring
// division of the frame length by the subframe count (skipped with no
// subframes). The sequencer goes idle as the result loads. Multiply,
// adds, subtract and divide share one 33-bit adder-subtractor under the sequencer.
// A finished result waits in the output register while the next access is
// accepted; if the receiver stalls, the following result holds in the
// sequencer until the register frees. Reset empties the outgoing queue,
// clears the command collector and drops any latched frame. The queue
// storage itself is not cleared; only written entries are ever read.
`timescale 1ns / 1ps
`default_nettype none

module dsp_mailbox_command_engine #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // [31:0] mail_word
  input  wire logic [dspmb_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // [2:0] command
  input  wire logic [dspmb_pkg::IN_USER_W-1:0]   s_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // [31:0] read_data, [32] irq_raised, [64:33] render_addr_a,
  // [96:65] render_addr_b, [128:97] sample_count, [144:129] master_level,
  // [145] frame_pending, [209:146] subframes_rendered,
  // [210] mailbox_overflow, [215:211] zero
  output logic [dspmb_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
  // [2:0] event_res
  output logic [dspmb_pkg::OUT_USER_W-1:0]       m_axis_tuser
);

  localparam int unsigned PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int unsigned FILL_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(QUEUE_DEPTH);

  // Sequencer states.
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_EXEC  = 4'd1;
  localparam logic [3:0] S_READ  = 4'd2;
  localparam logic [3:0] S_RUN   = 4'd3;
  localparam logic [3:0] S_MUL   = 4'd4;
  localparam logic [3:0] S_ADDA  = 4'd5;
  localparam logic [3:0] S_ADDB  = 4'd6;
  localparam logic [3:0] S_FSUB  = 4'd7;
  localparam logic [3:0] S_FDIV  = 4'd8;
  localparam logic [3:0] S_PUSH1 = 4'd9;
  localparam logic [3:0] S_PUSH2 = 4'd10;
  localparam logic [3:0] S_DONE  = 4'd11;

  // Control state.
  logic [3:0]        state_q, state_d;
  logic [PTR_W-1:0]  head_q, head_d;
  logic [PTR_W-1:0]  tail_q, tail_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic [31:0]       last_mail_q, last_mail_d;
  logic              collecting_q, collecting_d;
  logic              release_q, release_d;
  logic [31:0]       wanted_q, wanted_d;
  logic [31:0]       received_q, received_d;
  logic [7:0]        sf_total_q, sf_total_d;
  logic [7:0]        sf_index_q, sf_index_d;
  logic [31:0]       spf_q, spf_d;
  logic [15:0]       level_q, level_d;
  logic [31:0]       base_a_q, base_a_d;
  logic [31:0]       base_b_q, base_b_d;
  logic [63:0]       rendered_q, rendered_d;
  logic [4:0]        cnt_q, cnt_d;
  logic              out_valid_q, out_valid_d;

  // Working and payload registers.
  logic [2:0]        cmd_q, cmd_d;
  logic [31:0]       mail_q, mail_d;
  logic [31:0]       cw_q [3];
  logic              cw_we;
  logic [1:0]        cw_sel;
  logic [31:0]       acc_q, acc_d;
  logic [31:0]       mcand_q, mcand_d;
  logic [7:0]        mplier_q, mplier_d;
  logic [31:0]       quo_q, quo_d;
  logic [7:0]        rem_q, rem_d;
  logic [31:0]       push0_q, push0_d;
  logic [31:0]       push1_q, push1_d;
  logic [31:0]       rd_q, rd_d;
  logic              irq_q, irq_d;
  logic              drop_q, drop_d;
  logic [2:0]        ev_q, ev_d;
  logic [31:0]       addr_a_q, addr_a_d;
  logic [31:0]       addr_b_q, addr_b_d;
  logic [dspmb_pkg::OUT_DATA_W-1:0] out_data_q, out_data_d;
  logic [dspmb_pkg::OUT_USER_W-1:0] out_user_q, out_user_d;

  // Shared adder-subtractor.
  logic [31:0] alu_a, alu_b;
  logic        alu_sub;
  logic [32:0] alu_sum;

  // Queue memory port.
  logic        ram_we;
  logic [31:0] ram_wdata;
  logic [31:0] ram_rdata;

  logic [31:0] received_inc;
  logic [8:0]  rem_shift;
  logic        div_ge;
  logic        pending;
  logic        queue_full;
  logic [7:0]  opcode;
  logic        out_load;

  assign received_inc = received_q + 32'd1;
  assign rem_shift    = {rem_q, quo_q[31]};
  assign div_ge       = alu_sum[32];
  assign pending      = (base_a_q != 32'd0) && (sf_index_q < sf_total_q);
  assign queue_full   = (fill_q >= FILL_MAX);
  assign opcode       = cw_q[0][31:24];
  assign out_load     = (state_q == S_DONE) && (!out_valid_q || m_axis_tready);

  // Operand selection for the shared unit.
  always_comb begin
    alu_a   = 32'd0;
    alu_b   = 32'd0;
    alu_sub = 1'b0;
    unique case (state_q)
      S_MUL: begin
        alu_a = acc_q;
        alu_b = mcand_q;
      end
      S_ADDA: begin
        alu_a = base_a_q;
        alu_b = acc_q;
      end
      S_ADDB: begin
        alu_a = base_b_q;
        alu_b = acc_q;
      end
      S_FSUB: begin
        alu_a   = cw_q[2];
        alu_b   = cw_q[1];
        alu_sub = 1'b1;
      end
      S_FDIV: begin
        alu_a   = {23'd0, rem_shift};
        alu_b   = {24'd0, sf_total_q};
        alu_sub = 1'b1;
      end
      default: begin
        alu_a = 32'd0;
      end
    endcase
  end

  assign alu_sum = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)} + {32'd0, alu_sub};

  // Queue storage.
  assign ram_we    = ((state_q == S_PUSH1) || (state_q == S_PUSH2)) && !queue_full;
  assign ram_wdata = (state_q == S_PUSH1) ? push0_q : push1_q;

  dspmb_ram #(
    .WIDTH(32),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(tail_q),
    .wdata_i(ram_wdata),
    .raddr_i(head_q),
    .rdata_o(ram_rdata)
  );

  // Sequencer.
  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    tail_d       = tail_q;
    fill_d       = fill_q;
    last_mail_d  = last_mail_q;
    collecting_d = collecting_q;
    release_d    = release_q;
    wanted_d     = wanted_q;
    received_d   = received_q;
    sf_total_d   = sf_total_q;
    sf_index_d   = sf_index_q;
    spf_d        = spf_q;
    level_d      = level_q;
    base_a_d     = base_a_q;
    base_b_d     = base_b_q;
    rendered_d   = rendered_q;
    cnt_d        = cnt_q;
    cmd_d        = cmd_q;
    mail_d       = mail_q;
    cw_we        = 1'b0;
    cw_sel       = received_q[1:0];
    acc_d        = acc_q;
    mcand_d      = mcand_q;
    mplier_d     = mplier_q;
    quo_d        = quo_q;
    rem_d        = rem_q;
    push0_d      = push0_q;
    push1_d      = push1_q;
    rd_d         = rd_q;
    irq_d        = irq_q;
    drop_d       = drop_q;
    ev_d         = ev_q;
    addr_a_d     = addr_a_q;
    addr_b_d     = addr_b_q;

    unique case (state_q) inside
      S_IDLE: begin
        if (s_axis_tvalid) begin
          cmd_d    = s_axis_tuser;
          mail_d   = s_axis_tdata;
          rd_d     = 32'd0;
          irq_d    = 1'b0;
          drop_d   = 1'b0;
          ev_d     = dspmb_pkg::EV_NONE;
          addr_a_d = 32'd0;
          addr_b_d = 32'd0;
          state_d  = S_EXEC;
        end
      end

      S_EXEC: begin
        state_d = S_DONE;
        unique case (cmd_q) inside
          dspmb_pkg::CMD_WRITE: begin
            last_mail_d = mail_q;
            if (collecting_q) begin
              cw_we      = (received_q < 32'd3);
              received_d = received_inc;
              if (received_inc == wanted_q) begin
                collecting_d = 1'b0;
                state_d      = S_RUN;
              end
            end
          end
          dspmb_pkg::CMD_IRQ: begin
            release_d    = (last_mail_q == 32'd0);
            wanted_d     = (last_mail_q != 32'd0) ? last_mail_q : 32'd2;
            collecting_d = 1'b1;
            received_d   = 32'd0;
          end
          dspmb_pkg::CMD_CHECK, dspmb_pkg::CMD_READ: begin
            if (fill_q != '0) begin
              state_d = S_READ;
            end
          end
          dspmb_pkg::CMD_BOOT: begin
            push0_d = dspmb_pkg::MAIL_BOOT_HDR;
            push1_d = dspmb_pkg::MAIL_TAG;
            state_d = S_PUSH1;
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end

      // Queue front is in the registered read data now.
      S_READ: begin
        if (cmd_q == dspmb_pkg::CMD_CHECK) begin
          rd_d = dspmb_pkg::MAIL_PRESENT | {16'd0, ram_rdata[31:16]};
        end else begin
          rd_d   = ram_rdata;
          head_d = (head_q == PTR_LAST) ? '0 : head_q + PTR_W'(1);
          fill_d = fill_q - FILL_W'(1);
        end
        state_d = S_DONE;
      end

      // A complete command has been collected.
      S_RUN: begin
        state_d = S_DONE;
        if (release_q) begin
          if (pending) begin
            acc_d    = 32'd0;
            mcand_d  = {spf_q[30:0], 1'b0};
            mplier_d = sf_index_q;
            cnt_d    = 5'd0;
            state_d  = S_MUL;
          end
        end else if (opcode == dspmb_pkg::OP_FRAME) begin
          if (received_q >= 32'd3) begin
            sf_total_d = cw_q[0][23:16];
            level_d    = cw_q[0][15:0];
            base_a_d   = cw_q[1];
            base_b_d   = cw_q[2];
            sf_index_d = 8'd0;
            ev_d       = dspmb_pkg::EV_FRAME;
            state_d    = S_FSUB;
          end
        end else begin
          ev_d    = (opcode == dspmb_pkg::OP_SETUP) ? dspmb_pkg::EV_SETUP
                                                    : dspmb_pkg::EV_UNKNOWN;
          push0_d = dspmb_pkg::MAIL_REPLY_HDR;
          push1_d = dspmb_pkg::MAIL_TAG | {16'd0, cw_q[0][31:16]};
          state_d = S_PUSH1;
        end
      end

      // Offset = 2 * index * samples, one multiplier bit a step.
      S_MUL: begin
        if (mplier_q[0]) begin
          acc_d = alu_sum[31:0];
        end
        mcand_d  = {mcand_q[30:0], 1'b0};
        mplier_d = {1'b0, mplier_q[7:1]};
        cnt_d    = cnt_q + 5'd1;
        if (cnt_q[2:0] == 3'd7) begin
          state_d = S_ADDA;
        end
      end

      S_ADDA: begin
        addr_a_d = alu_sum[31:0];
        state_d  = S_ADDB;
      end

      S_ADDB: begin
        addr_b_d   = alu_sum[31:0];
        sf_index_d = sf_index_q + 8'd1;
        rendered_d = rendered_q + 64'd1;
        ev_d       = dspmb_pkg::EV_RENDER;
        push0_d    = dspmb_pkg::MAIL_REPLY_HDR;
        push1_d    = dspmb_pkg::MAIL_RENDERED;
        state_d    = S_PUSH1;
      end

      // Frame length in samples is half the byte distance.
      S_FSUB: begin
        quo_d = {1'b0, alu_sum[31:1]};
        rem_d = 8'd0;
        cnt_d = 5'd0;
        if (sf_total_q == 8'd0) begin
          spf_d   = 32'd0;
          state_d = S_DONE;
        end else begin
          state_d = S_FDIV;
        end
      end

      // Restoring division, one quotient bit a step.
      S_FDIV: begin
        rem_d = div_ge ? alu_sum[7:0] : rem_shift[7:0];
        quo_d = {quo_q[30:0], div_ge};
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          spf_d   = {quo_q[30:0], div_ge};
          state_d = S_DONE;
        end
      end

      S_PUSH1, S_PUSH2: begin
        irq_d = 1'b1;
        if (queue_full) begin
          drop_d = 1'b1;
        end else begin
          tail_d = (tail_q == PTR_LAST) ? '0 : tail_q + PTR_W'(1);
          fill_d = fill_q + FILL_W'(1);
        end
        state_d = (state_q == S_PUSH1) ? S_PUSH2 : S_DONE;
      end

      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output register contents.
  always_comb begin
    out_data_d = {5'd0, drop_q, rendered_q, pending, level_q, spf_q,
                  addr_b_q, addr_a_q, irq_q, rd_q};
    out_user_d = ev_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      head_q       <= '0;
      tail_q       <= '0;
      fill_q       <= '0;
      last_mail_q  <= 32'd0;
      collecting_q <= 1'b0;
      release_q    <= 1'b0;
      wanted_q     <= 32'd0;
      received_q   <= 32'd0;
      sf_total_q   <= 8'd0;
      sf_index_q   <= 8'd0;
      spf_q        <= 32'd0;
      level_q      <= 16'd0;
      base_a_q     <= 32'd0;
      base_b_q     <= 32'd0;
      rendered_q   <= 64'd0;
      cnt_q        <= 5'd0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      head_q       <= head_d;
      tail_q       <= tail_d;
      fill_q       <= fill_d;
      last_mail_q  <= last_mail_d;
      collecting_q <= collecting_d;
      release_q    <= release_d;
      wanted_q     <= wanted_d;
      received_q   <= received_d;
      sf_total_q   <= sf_total_d;
      sf_index_q   <= sf_index_d;
      spf_q        <= spf_d;
      level_q      <= level_d;
      base_a_q     <= base_a_d;
      base_b_q     <= base_b_d;
      rendered_q   <= rendered_d;
      cnt_q        <= cnt_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Working and payload registers.
  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    mail_q   <= mail_d;
    acc_q    <= acc_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
    quo_q    <= quo_d;
    rem_q    <= rem_d;
    push0_q  <= push0_d;
    push1_q  <= push1_d;
    rd_q     <= rd_d;
    irq_q    <= irq_d;
    drop_q   <= drop_d;
    ev_q     <= ev_d;
    addr_a_q <= addr_a_d;
    addr_b_q <= addr_b_d;
    if (cw_we) begin
      cw_q[cw_sel] <= mail_q;
    end
    if (out_load) begin
      out_data_q <= out_data_d;
      out_user_q <= out_user_d;
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  // The fill count never passes the queue depth.
  a_fill_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_MAX)
    else $error("queue fill count exceeds depth");

  // The queue is never written while full.
  a_no_write_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (fill_q < FILL_MAX))
    else $error("queue written while full");

  // A frame latch never raises the interrupt.
  a_frame_no_irq : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == dspmb_pkg::EV_FRAME)) |-> !m_axis_tdata[32])
    else $error("frame latch reported an interrupt");

  // The render counter only moves at the end of a render.
  a_render_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rendered_q != $past(rendered_q)) |-> ($past(state_q) == S_ADDB))
    else $error("render counter changed outside a render");

endmodule

`default_nettype wire
